/* design/cfmd_pkg.sv */
// shared types, constants and helpers for the cheapest fuel monotonic deque
// no dependencies
package cfmd_pkg;

    localparam int LOT_DEPTH = 1024;
    localparam int IDX_W     = $clog2(LOT_DEPTH);
    localparam int CNT_W     = $clog2(LOT_DEPTH + 1);

    localparam logic       OP_STATION   = 1'b0;
    localparam logic       OP_FINISH    = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic        op;
        logic [31:0] price;
        logic [31:0] distance;
    } in_t;

    typedef struct packed {
        logic [31:0] total_cost;
        logic [31:0] fuel_left;
        logic [1:0]  status;
    } out_t;

    typedef struct packed {
        logic [31:0] price;
        logic [31:0] litres;
    } lot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP_CHK,
        ST_POP_EVAL,
        ST_POP_SUB,
        ST_BUY,
        ST_BUY_ADD,
        ST_BURN_CHK,
        ST_BURN_EVAL,
        ST_FINAL,
        ST_FINISH
    } state_t;

    // ring slot of head plus offset, both below the depth
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] offset);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= (IDX_W+1)'(LOT_DEPTH))
            sum = sum - (IDX_W+1)'(LOT_DEPTH);
        return sum[IDX_W-1:0];
    endfunction

endpackage

/* design/cfmd_lot_store.sv */
// lot memory: one write port, one registered read port
// depends on cfmd_pkg
module cfmd_lot_store
    import cfmd_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  lot_t             wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output lot_t             rd_data
);

    lot_t mem [LOT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

/* design/cfmd_mul.sv */
// shared 32x32 multiplier, low half of the product, registered
// depends on cfmd_pkg
module cfmd_mul
    import cfmd_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] product
);

    // only the low half is kept, so a 32x32 multiply is enough
    logic [31:0] full;

    assign full = a * b;

    always_ff @(posedge clk)
    begin
        product <= full;
    end

endmodule

/* design/cheapest_fuel_monotonic_deque.sv */
// cheapest fuel monotonic deque, top level: sequencer, state registers, output register
// a station beat refunds back lots priced above it, buys fuel to fill the tank when the deque
//   has room, then burns front lots along the distance; a finish beat refunds every lot held
//   and clears the deque; the last state waits while a stalled result holds the output
// throughput: one beat in flight, next beat taken the cycle after its result is loaded
// reset (rst_n low, async): empty deque, zero cost, fuel and tank_capacity; memory not cleared
module cheapest_fuel_monotonic_deque
    import cfmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data
);

    // sequencer state
    state_t state_reg, state_next;

    // deque bookkeeping and running totals
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      fuel_reg, fuel_next;
    logic [31:0]      cost_reg, cost_next;
    logic [1:0]       status_reg, status_next;
    logic [31:0]      cap_reg;

    // current beat
    logic             op_reg;
    logic [31:0]      price_reg;
    logic [31:0]      dist_reg, dist_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    out_t             out_data_reg, out_data_next;

    // memory and multiplier hookups
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    lot_t             wr_data, rd_data;
    logic [31:0]      mul_a, mul_b, mul_p;

    // decode helpers
    logic             in_accept;
    logic             out_free;
    logic             pop_hit;
    logic             deque_full;
    logic             need_buy;
    logic [31:0]      buy;
    logic [IDX_W-1:0] back_off;
    logic [IDX_W-1:0] head_inc;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // finish pops every lot, a station pops lots priced above it
    assign pop_hit    = (op_reg == OP_FINISH) || (rd_data.price > price_reg);
    assign deque_full = (count_reg == CNT_W'(LOT_DEPTH));
    assign need_buy   = (fuel_reg < cap_reg);
    assign buy        = cap_reg - fuel_reg;
    assign back_off   = IDX_W'(count_reg - CNT_W'(1));
    assign head_inc   = (head_reg == IDX_W'(LOT_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);

    cfmd_lot_store u_lot_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cfmd_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_POP_CHK;
            end
            ST_POP_CHK:
            begin
                if (count_reg != '0)
                    state_next = ST_POP_EVAL;
                else if (op_reg == OP_FINISH)
                    state_next = ST_FINISH;
                else
                    state_next = ST_BUY;
            end
            ST_POP_EVAL:  state_next = pop_hit ? ST_POP_SUB : ST_BUY;
            ST_POP_SUB:   state_next = ST_POP_CHK;
            ST_BUY:       state_next = (need_buy && !deque_full) ? ST_BUY_ADD : ST_BURN_CHK;
            ST_BUY_ADD:   state_next = ST_BURN_CHK;
            ST_BURN_CHK:
            begin
                if (dist_reg != '0 && count_reg != '0)
                    state_next = ST_BURN_EVAL;
                else
                    state_next = ST_FINAL;
            end
            ST_BURN_EVAL: state_next = ST_BURN_CHK;
            ST_FINAL:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls per state
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        fuel_next      = fuel_reg;
        cost_next      = cost_reg;
        status_next    = status_reg;
        dist_next      = dist_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = head_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        mul_a          = rd_data.price;
        mul_b          = rd_data.litres;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    dist_next   = in_data.distance;
                    status_next = STATUS_OK;
                end
            end
            ST_POP_CHK:
            begin
                // fetch the back lot
                if (count_reg != '0)
                begin
                    rd_en   = 1'b1;
                    rd_addr = slot_of(head_reg, back_off);
                end
            end
            ST_POP_EVAL:
            begin
                // multiplier works on the back lot this cycle
                if (pop_hit)
                begin
                    fuel_next  = fuel_reg - rd_data.litres;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_POP_SUB:
            begin
                cost_next = cost_reg - mul_p;
            end
            ST_BUY:
            begin
                if (need_buy)
                begin
                    if (deque_full)
                        status_next = STATUS_FULL;
                    else
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = slot_of(head_reg, count_reg[IDX_W-1:0]);
                        wr_data.price  = price_reg;
                        wr_data.litres = buy;
                        count_next     = count_reg + CNT_W'(1);
                        fuel_next      = cap_reg;
                        mul_a          = price_reg;
                        mul_b          = buy;
                    end
                end
            end
            ST_BUY_ADD:
            begin
                cost_next = cost_reg + mul_p;
            end
            ST_BURN_CHK:
            begin
                // fetch the front lot
                if (dist_reg != '0 && count_reg != '0)
                    rd_en = 1'b1;
            end
            ST_BURN_EVAL:
            begin
                if (rd_data.litres <= dist_reg)
                begin
                    // front lot drained
                    dist_next  = dist_reg - rd_data.litres;
                    fuel_next  = fuel_reg - rd_data.litres;
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    // partial burn, write back what is left
                    wr_en          = 1'b1;
                    wr_data.price  = rd_data.price;
                    wr_data.litres = rd_data.litres - dist_reg;
                    fuel_next      = fuel_reg - dist_reg;
                    dist_next      = '0;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.total_cost = cost_reg;
                    if (dist_reg != '0)
                    begin
                        // ran dry, tank empty
                        fuel_next               = '0;
                        out_data_next.fuel_left = '0;
                        out_data_next.status    = STATUS_SHORT;
                    end
                    else
                    begin
                        out_data_next.fuel_left = fuel_reg;
                        out_data_next.status    = status_reg;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.total_cost = cost_reg;
                    out_data_next.fuel_left  = '0;
                    out_data_next.status     = STATUS_OK;
                    cost_next                = '0;
                    fuel_next                = '0;
                    head_next                = '0;
                    count_next               = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            fuel_reg      <= '0;
            cost_reg      <= '0;
            status_reg    <= STATUS_OK;
            out_valid_reg <= 1'b0;
            cap_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            fuel_reg      <= fuel_next;
            cost_reg      <= cost_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= in_data.op;
            price_reg <= in_data.price;
        end
        dist_reg     <= dist_next;
        out_data_reg <= out_data_next;
    end

    // the deque never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LOT_DEPTH))
        else $error("lot count beyond depth");

    // an empty deque holds no fuel between beats
    a_empty_no_fuel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && count_reg == '0) |-> (fuel_reg == '0))
        else $error("fuel held with empty deque");

    // a taken input beat keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input taken twice in a row");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && (state_reg == ST_FINAL || state_reg == ST_FINISH))
        |=> (state_reg == $past(state_reg)))
        else $error("result loaded over a stalled one");

endmodule
